@@ sv/stop_and_wait_transfer_controller_core_assert.svh @@
// Assertion macros for the stop-and-wait transfer controller checkers
`ifndef STOP_AND_WAIT_TRANSFER_CONTROLLER_CORE_ASSERT_SVH
`define STOP_AND_WAIT_TRANSFER_CONTROLLER_CORE_ASSERT_SVH

// checked only outside reset
`define SWTC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("swtc assertion failed");

// checked at every edge, reset included
`define SWTC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("swtc assertion failed");

`endif

@@ sv/swtc_pkg.sv @@
// Shared types and constants of the stop-and-wait transfer controller
package swtc_pkg;

   localparam int CMD_W     = 2;
   localparam int LEN_W     = 32;
   localparam int KIND_W    = 3;
   localparam int TAG_W     = 8;
   localparam int PCT_W     = 7;
   localparam int TIMER_W   = 16;
   localparam int COUNT_W   = 4;
   localparam int SENT_W    = LEN_W + 1;
   localparam int PROD_W    = SENT_W + PCT_W;
   localparam int STEP_W    = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam int PACKET_BYTES = 16;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_AW     = 1;
   localparam int QUEUE_CW     = 2;

   localparam logic [TIMER_W-1:0] RETRY_RESET     = 16'd2000;
   localparam logic [COUNT_W-1:0] MAX_SENDS_RESET = 4'd3;
   localparam logic [TAG_W-1:0]   DEV_TYPE_RESET  = 8'd0;
   localparam logic [PCT_W-1:0]   PERCENT_FULL    = 7'd100;

   localparam logic [CMD_W-1:0] CMD_START = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ACK   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_STOP  = 2'd3;

   localparam logic [KIND_W-1:0] K_HEADER   = 3'd0;
   localparam logic [KIND_W-1:0] K_DATA     = 3'd1;
   localparam logic [KIND_W-1:0] K_PROGRESS = 3'd2;
   localparam logic [KIND_W-1:0] K_FAILED   = 3'd3;
   localparam logic [KIND_W-1:0] K_DONE     = 3'd4;
   localparam logic [KIND_W-1:0] K_REJECTED = 3'd5;

   localparam logic [CSR_IDX_W-1:0] REG_RETRY     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_SENDS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEV_TYPE  = 2'd2;

   typedef struct packed {
      logic [TIMER_W-1:0] retry_interval;
      logic [COUNT_W-1:0] max_sends;
      logic [TAG_W-1:0]   device_type;
   } cfg_type;

   typedef struct packed {
      logic [CMD_W-1:0] op;
      logic [LEN_W-1:0] length;
   } entry_type;

endpackage

@@ sv/swtc_ifs.sv @@
// Handshake channel interfaces: request, response and register write
interface swtc_req_if import swtc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic [LEN_W-1:0] total_length;
   modport source (output valid, command, total_length, input ready);
   modport sink (input valid, command, total_length, output ready);
endinterface

interface swtc_rsp_if import swtc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [TAG_W-1:0]  packet_tag;
   logic [LEN_W-1:0]  payload;
   logic [PCT_W-1:0]  percent;
   modport source (output valid, kind, packet_tag, payload, percent, input ready);
   modport sink (input valid, kind, packet_tag, payload, percent, output ready);
endinterface

interface swtc_csr_if import swtc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ sv/swtc_csr.sv @@
// Configuration registers of the transfer controller
module swtc_csr import swtc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   swtc_csr_if.sink   csr,
   output cfg_type    cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            REG_RETRY:     cfg_in.retry_interval = csr.data;
            REG_MAX_SENDS: cfg_in.max_sends      = csr.data[COUNT_W-1:0];
            REG_DEV_TYPE:  cfg_in.device_type    = csr.data[TAG_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.retry_interval <= RETRY_RESET;
         cfg_ff.max_sends      <= MAX_SENDS_RESET;
         cfg_ff.device_type    <= DEV_TYPE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ sv/swtc_front.sv @@
// Request front end: takes words and sorts them into queue entries
module swtc_front import swtc_pkg::*; (
   swtc_req_if.sink   req,
   input  logic       push_ready,
   output logic       push_valid,
   output entry_type  push_data
);

   assign req.ready  = push_ready;
   assign push_valid = req.valid;

   always_comb begin
      push_data.op = req.command;
      case (req.command)
         CMD_START: push_data.length = req.total_length;
         default:   push_data.length = '0;
      endcase
   end

endmodule

@@ sv/swtc_queue.sv @@
// Two-entry queue between front end and command engine
module swtc_queue import swtc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_data,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_data
);

   entry_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]    count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_ready = (count_ff != QUEUE_CW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ sv/swtc_back.sv @@
// Command engine: transfer state, retry timing, percent divider, response register
module swtc_back import swtc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       pop_valid,
   output logic       pop_ready,
   input  entry_type  pop_data,
   swtc_rsp_if.source rsp
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic                running_ff, running_in;
   logic                armed_ff, armed_in;
   logic                first_due_ff, first_due_in;
   logic [COUNT_W-1:0]  send_cnt_ff, send_cnt_in;
   logic [TIMER_W-1:0]  timer_ff, timer_in;
   logic                hdr_ff, hdr_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic [LEN_W-1:0]    pay_ff, pay_in;
   logic [LEN_W-1:0]    total_ff, total_in;
   logic [SENT_W-1:0]   sent_ff, sent_in;
   logic [TAG_W-1:0]    pid_ff, pid_in;

   logic [PROD_W-1:0]   rem_ff, rem_in;
   logic [PROD_W-1:0]   dvs_ff, dvs_in;
   logic [PCT_W-1:0]    quo_ff, quo_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   logic                out_valid_ff, out_valid_in;
   logic [KIND_W-1:0]   out_kind_ff, out_kind_in;
   logic [TAG_W-1:0]    out_tag_ff, out_tag_in;
   logic [LEN_W-1:0]    out_pay_ff, out_pay_in;
   logic [PCT_W-1:0]    out_pct_ff, out_pct_in;

   logic [TIMER_W-1:0]  timer_inc;
   logic                rem_ge;

   assign pop_ready      = (state_ff == S_IDLE) && !out_valid_ff;
   assign rsp.valid      = out_valid_ff;
   assign rsp.kind       = out_kind_ff;
   assign rsp.packet_tag = out_tag_ff;
   assign rsp.payload    = out_pay_ff;
   assign rsp.percent    = out_pct_ff;

   assign timer_inc = (timer_ff == '1) ? timer_ff : timer_ff + 1'b1;
   assign rem_ge    = (rem_ff >= dvs_ff);

   always_comb begin
      state_in     = state_ff;
      running_in   = running_ff;
      armed_in     = armed_ff;
      first_due_in = first_due_ff;
      send_cnt_in  = send_cnt_ff;
      timer_in     = timer_ff;
      hdr_in       = hdr_ff;
      tag_in       = tag_ff;
      pay_in       = pay_ff;
      total_in     = total_ff;
      sent_in      = sent_ff;
      pid_in       = pid_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_kind_in  = out_kind_ff;
      out_tag_in   = out_tag_ff;
      out_pay_in   = out_pay_ff;
      out_pct_in   = out_pct_ff;

      case (state_ff)
         S_IDLE: begin
            if (pop_valid && pop_ready) begin
               out_tag_in = '0;
               out_pay_in = '0;
               out_pct_in = '0;
               case (pop_data.op)
                  CMD_START: begin
                     if (running_ff) begin
                        out_valid_in = 1'b1;
                        out_kind_in  = K_REJECTED;
                     end else begin
                        total_in     = pop_data.length;
                        sent_in      = '0;
                        running_in   = 1'b1;
                        pid_in       = '0;
                        armed_in     = 1'b1;
                        first_due_in = 1'b1;
                        send_cnt_in  = '0;
                        timer_in     = '0;
                        hdr_in       = 1'b1;
                        tag_in       = cfg.device_type;
                        pay_in       = pop_data.length;
                     end
                  end
                  CMD_STOP: begin
                     running_in   = 1'b0;
                     armed_in     = 1'b0;
                     first_due_in = 1'b0;
                     send_cnt_in  = '0;
                     timer_in     = '0;
                     hdr_in       = 1'b0;
                     tag_in       = '0;
                     pay_in       = '0;
                     total_in     = '0;
                     sent_in      = '0;
                     pid_in       = '0;
                  end
                  CMD_ACK: begin
                     if (running_ff) begin
                        if (sent_ff >= SENT_W'(total_ff)) begin
                           out_valid_in = 1'b1;
                           out_kind_in  = K_DONE;
                        end else begin
                           armed_in     = 1'b1;
                           first_due_in = 1'b1;
                           send_cnt_in  = '0;
                           timer_in     = '0;
                           hdr_in       = 1'b0;
                           tag_in       = pid_ff;
                           pay_in       = sent_ff[LEN_W-1:0];
                           pid_in       = pid_ff + 1'b1;
                           sent_in      = sent_ff + SENT_W'(PACKET_BYTES);
                           out_kind_in  = K_PROGRESS;
                           out_tag_in   = pid_ff;
                           state_in     = S_MUL;
                        end
                     end
                  end
                  CMD_TICK: begin
                     if (running_ff && armed_ff) begin
                        if (first_due_ff || timer_inc >= cfg.retry_interval) begin
                           first_due_in = 1'b0;
                           out_valid_in = 1'b1;
                           if (send_cnt_ff >= cfg.max_sends) begin
                              armed_in    = 1'b0;
                              out_kind_in = K_FAILED;
                              if (!first_due_ff) begin
                                 timer_in = timer_inc;
                              end
                           end else begin
                              timer_in    = '0;
                              send_cnt_in = send_cnt_ff + 1'b1;
                              out_kind_in = hdr_ff ? K_HEADER : K_DATA;
                              out_tag_in  = tag_ff;
                              out_pay_in  = pay_ff;
                           end
                        end else begin
                           timer_in = timer_inc;
                        end
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_MUL: begin
            if (sent_ff >= SENT_W'(total_ff)) begin
               out_pct_in   = PERCENT_FULL;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               rem_in   = PROD_W'(sent_ff) * PROD_W'(PERCENT_FULL);
               dvs_in   = PROD_W'(total_ff) << (PCT_W - 1);
               quo_in   = '0;
               step_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (rem_ge) begin
               rem_in = rem_ff - dvs_ff;
            end
            quo_in  = {quo_ff[PCT_W-2:0], rem_ge};
            dvs_in  = dvs_ff >> 1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(PCT_W - 1)) begin
               out_pct_in   = quo_in;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         running_ff   <= 1'b0;
         armed_ff     <= 1'b0;
         first_due_ff <= 1'b0;
         send_cnt_ff  <= '0;
         timer_ff     <= '0;
         hdr_ff       <= 1'b0;
         tag_ff       <= '0;
         pay_ff       <= '0;
         total_ff     <= '0;
         sent_ff      <= '0;
         pid_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         armed_ff     <= armed_in;
         first_due_ff <= first_due_in;
         send_cnt_ff  <= send_cnt_in;
         timer_ff     <= timer_in;
         hdr_ff       <= hdr_in;
         tag_ff       <= tag_in;
         pay_ff       <= pay_in;
         total_ff     <= total_in;
         sent_ff      <= sent_in;
         pid_ff       <= pid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      out_kind_ff <= out_kind_in;
      out_tag_ff  <= out_tag_in;
      out_pay_ff  <= out_pay_in;
      out_pct_ff  <= out_pct_in;
   end

endmodule

@@ sv/stop_and_wait_transfer_controller_core.sv @@
// Responses: an accepted word with a response has it registered in the response
// register; a progress response runs the multiply state, then seven divider steps
// unless all bytes are sent. The engine takes one word per cycle when nothing is
// answered, none while a response is pending; a two-word queue decouples.
// Reset: synchronous; clears the transfer state, the queue and the response register,
// and loads the register defaults (interval 2000, three sends, device type 0).
module stop_and_wait_transfer_controller_core import swtc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   swtc_req_if.sink   req_bus,
   swtc_rsp_if.source rsp_bus,
   swtc_csr_if.sink   csr_bus
);

   cfg_type   cfg;
   logic      push_valid, push_ready;
   entry_type push_data;
   logic      pop_valid, pop_ready;
   entry_type pop_data;

   swtc_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_bus),
      .cfg   (cfg)
   );

   swtc_front u_front (
      .req        (req_bus),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   swtc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   swtc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp       (rsp_bus)
   );

endmodule

@@ sv/swtc_checker.sv @@
// Port-level checker for the transfer controller, bound to the top level
`include "stop_and_wait_transfer_controller_core_assert.svh"

module swtc_checker import swtc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [KIND_W-1:0] rsp_kind,
   input logic [TAG_W-1:0]  rsp_tag,
   input logic [LEN_W-1:0]  rsp_payload,
   input logic [PCT_W-1:0]  rsp_percent
);

   `SWTC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_tag) && $stable(rsp_payload) && $stable(rsp_percent))
   `SWTC_ASSERT(a_pct_range, clock, reset, rsp_valid |-> rsp_percent <= PERCENT_FULL)
   `SWTC_ASSERT(a_pct_only_progress, clock, reset, rsp_valid && rsp_kind != K_PROGRESS |-> rsp_percent == '0)
   `SWTC_ASSERT(a_status_empty, clock, reset, rsp_valid && (rsp_kind == K_FAILED || rsp_kind == K_DONE || rsp_kind == K_REJECTED) |-> rsp_tag == '0 && rsp_payload == '0)
   `SWTC_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_valid)

endmodule

bind stop_and_wait_transfer_controller_core swtc_checker u_swtc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_kind    (rsp_bus.kind),
   .rsp_tag     (rsp_bus.packet_tag),
   .rsp_payload (rsp_bus.payload),
   .rsp_percent (rsp_bus.percent)
);
